### design/msrpm_pkg.sv
// ----------------------------------------------------------------------------
// MSR permission map package
// Shared constants, request codes and sequencer states for the rotating
// MSR permission map.
// ----------------------------------------------------------------------------
package msrpm_pkg;

  localparam int MAP_BYTES    = 8192;
  localparam int BUFFER_COUNT = 3;
  localparam int TOTAL_BYTES  = BUFFER_COUNT * MAP_BYTES;
  localparam int ADDR_W       = $clog2(TOTAL_BYTES);
  localparam int OFF_W        = 13;
  localparam int BUF_W        = 2;

  localparam logic [18:0] RANGE_LOW_TAG  = 19'h00000;
  localparam logic [18:0] RANGE_C000_TAG = 19'h60000;
  localparam logic [18:0] RANGE_C001_TAG = 19'h60008;

  localparam logic [OFF_W-1:0] BASE_LOW  = 13'h0000;
  localparam logic [OFF_W-1:0] BASE_C000 = 13'h0800;
  localparam logic [OFF_W-1:0] BASE_C001 = 13'h1000;

  localparam logic [BUF_W-1:0] RESET_ACTIVE = 2'd0;
  localparam logic [BUF_W-1:0] RESET_SHADOW = 2'd1;
  localparam logic [BUF_W-1:0] RESET_SPARE  = 2'd2;

  typedef enum logic [1:0] {
    FUNC_GET    = 2'd0,
    FUNC_MODIFY = 2'd1,
    FUNC_BEGIN  = 2'd2,
    FUNC_COMMIT = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_EXEC,
    ST_SWEEP
  } state_t;

endpackage

### design/msr_permission_map_rotating_unit.sv
// ----------------------------------------------------------------------------
// MSR permission map with rotating buffers
// Three byte-wide permission maps in one single-port memory, with active,
// shadow and spare roles, driven by a small sequencer.
// ----------------------------------------------------------------------------
// One request is handled at a time and the input is stalled until its result
// has been taken. A get or modify of a mapped MSR passes through decode,
// memory read, then check or write back through the single memory port; an
// unmapped MSR and a commit are answered from the idle state. A begin build
// clears all 8192 bytes of the shadow map through the memory port one byte
// per cycle. After reset the whole memory of 24576 bytes is cleared the same
// way before the first request is accepted.
module msr_permission_map_rotating_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_func,
  input  logic [31:0] in_msr,
  input  logic       in_read_sel,
  input  logic       in_write_sel,
  input  logic       in_set_bits,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_ok,
  output logic       out_read_intercept,
  output logic       out_write_intercept,
  output logic [1:0] out_active_buffer
);
  import msrpm_pkg::*;

  state_t state_r, state_nxt;

  logic [ADDR_W-1:0] cnt_r, cnt_nxt;
  logic [BUF_W-1:0]  active_r, active_nxt;
  logic [BUF_W-1:0]  shadow_r, shadow_nxt;
  logic [BUF_W-1:0]  spare_r, spare_nxt;
  logic              target_shadow_r, target_shadow_nxt;

  logic              func_get_r, func_get_nxt;
  logic [OFF_W-1:0]  off_r, off_nxt;
  logic [1:0]        pos_r, pos_nxt;
  logic              rsel_r, rsel_nxt;
  logic              wsel_r, wsel_nxt;
  logic              setb_r, setb_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic              ok_r, ok_nxt;
  logic              rd_r, rd_nxt;
  logic              wr_r, wr_nxt;

  logic [7:0]        mem [TOTAL_BYTES];
  logic [7:0]        rd_data_r;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_addr;
  logic [7:0]        mem_wdata;

  logic              accept;
  logic              mapped;
  logic [OFF_W-1:0]  dec_base;
  logic [OFF_W-1:0]  dec_off;
  logic [BUF_W-1:0]  tgt_buf;
  logic [7:0]        bit_mask;

  assign in_stall = (state_r != ST_IDLE) || out_valid_r;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    mapped   = 1'b1;
    dec_base = BASE_LOW;
    if (in_msr[31:13] == RANGE_LOW_TAG) begin
      dec_base = BASE_LOW;
    end else if (in_msr[31:13] == RANGE_C000_TAG) begin
      dec_base = BASE_C000;
    end else if (in_msr[31:13] == RANGE_C001_TAG) begin
      dec_base = BASE_C001;
    end else begin
      mapped = 1'b0;
    end
    dec_off = dec_base + {2'b00, in_msr[12:2]};
  end

  always_comb begin
    tgt_buf  = (!func_get_r && target_shadow_r) ? shadow_r : active_r;
    bit_mask = 8'h00;
    bit_mask[{pos_r, 1'b0}] = rsel_r;
    bit_mask[{pos_r, 1'b1}] = wsel_r;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (cnt_r == ADDR_W'(TOTAL_BYTES - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          case (in_func)
            FUNC_GET, FUNC_MODIFY: state_nxt = mapped ? ST_READ : ST_IDLE;
            FUNC_BEGIN:            state_nxt = ST_SWEEP;
            default:               state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_READ:  state_nxt = ST_EXEC;
      ST_EXEC:  state_nxt = ST_IDLE;
      ST_SWEEP: begin
        if (cnt_r == ADDR_W'(MAP_BYTES - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      default:  state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    cnt_nxt           = cnt_r;
    active_nxt        = active_r;
    shadow_nxt        = shadow_r;
    spare_nxt         = spare_r;
    target_shadow_nxt = target_shadow_r;
    func_get_nxt      = func_get_r;
    off_nxt           = off_r;
    pos_nxt           = pos_r;
    rsel_nxt          = rsel_r;
    wsel_nxt          = wsel_r;
    setb_nxt          = setb_r;
    out_valid_nxt     = out_valid_r && out_stall;
    ok_nxt            = ok_r;
    rd_nxt            = rd_r;
    wr_nxt            = wr_r;
    mem_we            = 1'b0;
    mem_addr          = ADDR_W'(tgt_buf) * ADDR_W'(MAP_BYTES) + ADDR_W'(off_r);
    mem_wdata         = setb_r ? (rd_data_r | bit_mask) : (rd_data_r & ~bit_mask);
    case (state_r)
      ST_CLEAR: begin
        mem_we   = 1'b1;
        mem_addr = cnt_r;
        mem_wdata = 8'h00;
        cnt_nxt  = cnt_r + ADDR_W'(1);
      end
      ST_IDLE: begin
        if (accept) begin
          func_get_nxt = (in_func == FUNC_GET);
          off_nxt      = dec_off;
          pos_nxt      = in_msr[1:0];
          rsel_nxt     = in_read_sel;
          wsel_nxt     = in_write_sel;
          setb_nxt     = in_set_bits;
          cnt_nxt      = '0;
          ok_nxt       = 1'b0;
          rd_nxt       = 1'b0;
          wr_nxt       = 1'b0;
          case (in_func)
            FUNC_GET, FUNC_MODIFY: begin
              out_valid_nxt = !mapped;
            end
            FUNC_BEGIN: begin
              target_shadow_nxt = 1'b1;
            end
            default: begin
              active_nxt        = shadow_r;
              shadow_nxt        = spare_r;
              spare_nxt         = active_r;
              target_shadow_nxt = 1'b0;
              ok_nxt            = 1'b1;
              out_valid_nxt     = 1'b1;
            end
          endcase
        end
      end
      ST_READ: begin
      end
      ST_EXEC: begin
        mem_we        = !func_get_r;
        ok_nxt        = 1'b1;
        rd_nxt        = func_get_r && rd_data_r[{pos_r, 1'b0}];
        wr_nxt        = func_get_r && rd_data_r[{pos_r, 1'b1}];
        out_valid_nxt = 1'b1;
      end
      ST_SWEEP: begin
        mem_we    = 1'b1;
        mem_addr  = ADDR_W'(shadow_r) * ADDR_W'(MAP_BYTES) + cnt_r;
        mem_wdata = 8'h00;
        cnt_nxt   = cnt_r + ADDR_W'(1);
        if (cnt_r == ADDR_W'(MAP_BYTES - 1)) begin
          ok_nxt        = 1'b1;
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    rd_data_r <= mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ST_CLEAR;
      cnt_r           <= '0;
      active_r        <= RESET_ACTIVE;
      shadow_r        <= RESET_SHADOW;
      spare_r         <= RESET_SPARE;
      target_shadow_r <= 1'b0;
      out_valid_r     <= 1'b0;
    end else begin
      state_r         <= state_nxt;
      cnt_r           <= cnt_nxt;
      active_r        <= active_nxt;
      shadow_r        <= shadow_nxt;
      spare_r         <= spare_nxt;
      target_shadow_r <= target_shadow_nxt;
      out_valid_r     <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_get_r <= func_get_nxt;
    off_r      <= off_nxt;
    pos_r      <= pos_nxt;
    rsel_r     <= rsel_nxt;
    wsel_r     <= wsel_nxt;
    setb_r     <= setb_nxt;
    ok_r       <= ok_nxt;
    rd_r       <= rd_nxt;
    wr_r       <= wr_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_ok              = ok_r;
  assign out_read_intercept  = rd_r;
  assign out_write_intercept = wr_r;
  assign out_active_buffer   = active_r;

endmodule

### test/msr_permission_map_rotating_unit_tb.sv
// ----------------------------------------------------------------------------
// Rotating MSR permission map testbench
// Sends get, modify, begin-build and commit requests with random idle gaps
// and result stalls. Every accepted request is run through a model of the
// three rotating maps, and each result is compared field by field with the
// oldest expected result.
// ----------------------------------------------------------------------------
module msr_permission_map_rotating_unit_tb;
  import msrpm_pkg::*;

  localparam int RANDOM_ITEMS = 1400;
  localparam int POOL_SIZE    = 8;
  localparam int POOL_IDX_W   = $clog2(POOL_SIZE);
  localparam int BOUNDARY_CNT = 12;
  localparam int BND_IDX_W    = $clog2(BOUNDARY_CNT);
  localparam int MAX_BUILDS   = 30;

  typedef struct packed {
    func_t       func;
    logic [31:0] msr;
    logic        read_sel;
    logic        write_sel;
    logic        set_bits;
    logic        quiet;
  } msr_request_t;

  typedef struct packed {
    logic       ok;
    logic       read_icpt;
    logic       write_icpt;
    logic [1:0] active;
  } intercept_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_func = FUNC_GET;
  logic [31:0] in_msr = '0;
  logic        in_read_sel = 1'b0;
  logic        in_write_sel = 1'b0;
  logic        in_set_bits = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_ok;
  logic        out_read_intercept;
  logic        out_write_intercept;
  logic [1:0]  out_active_buffer;

  msr_request_t      pending_requests_q[$];
  intercept_result_t expected_results_q[$];
  msr_request_t      cur_request;
  int                gap_left = 0;
  int                stall_left = 0;
  int                results_seen = 0;
  int                mismatch_count = 0;

  logic [7:0]  perm_map [TOTAL_BYTES];
  logic [1:0]  role_active = RESET_ACTIVE;
  logic [1:0]  role_shadow = RESET_SHADOW;
  logic [1:0]  role_spare = RESET_SPARE;
  logic        build_targets_shadow = 1'b0;
  logic [31:0] msr_pool [POOL_SIZE];
  logic [31:0] boundary_msrs [BOUNDARY_CNT];

  msr_permission_map_rotating_unit i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_func             (in_func),
    .in_msr              (in_msr),
    .in_read_sel         (in_read_sel),
    .in_write_sel        (in_write_sel),
    .in_set_bits         (in_set_bits),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_ok              (out_ok),
    .out_read_intercept  (out_read_intercept),
    .out_write_intercept (out_write_intercept),
    .out_active_buffer   (out_active_buffer)
  );

  always #4 clk = ~clk;

  function automatic logic decode_msr_slot(input logic [31:0] msr,
                                           output logic [OFF_W-1:0] byte_off,
                                           output logic [2:0] bit_off);
    logic [OFF_W-1:0] base;
    logic             hit;
    hit = 1'b1;
    base = BASE_LOW;
    if (msr <= 32'h0000_1FFF) begin
      base = BASE_LOW;
    end else if (msr >= 32'hC000_0000 && msr <= 32'hC000_1FFF) begin
      base = BASE_C000;
    end else if (msr >= 32'hC001_0000 && msr <= 32'hC001_1FFF) begin
      base = BASE_C001;
    end else begin
      hit = 1'b0;
    end
    byte_off = base + OFF_W'(msr[12:2]);
    bit_off = {msr[1:0], 1'b0};
    return hit;
  endfunction

  function automatic intercept_result_t predict_intercept_result(input msr_request_t req);
    intercept_result_t res;
    logic [OFF_W-1:0]  byte_off;
    logic [2:0]        bit_off;
    logic [7:0]        mask;
    logic [1:0]        retiring;
    logic [ADDR_W-1:0] idx;
    logic [ADDR_W-1:0] base_idx;
    res = '0;
    case (req.func)
      FUNC_GET: begin
        if (decode_msr_slot(req.msr, byte_off, bit_off)) begin
          idx = ADDR_W'(role_active) * ADDR_W'(MAP_BYTES) + ADDR_W'(byte_off);
          res.ok = 1'b1;
          res.read_icpt = perm_map[idx][bit_off];
          res.write_icpt = perm_map[idx][bit_off + 3'd1];
        end
      end
      FUNC_MODIFY: begin
        if (decode_msr_slot(req.msr, byte_off, bit_off)) begin
          idx = ADDR_W'(build_targets_shadow ? role_shadow : role_active) * ADDR_W'(MAP_BYTES)
                + ADDR_W'(byte_off);
          mask = '0;
          if (req.read_sel) mask[bit_off] = 1'b1;
          if (req.write_sel) mask[bit_off + 3'd1] = 1'b1;
          perm_map[idx] = req.set_bits ? (perm_map[idx] | mask) : (perm_map[idx] & ~mask);
          res.ok = 1'b1;
        end
      end
      FUNC_BEGIN: begin
        base_idx = ADDR_W'(role_shadow) * ADDR_W'(MAP_BYTES);
        for (int i = 0; i < MAP_BYTES; i++) begin
          perm_map[base_idx + ADDR_W'(i)] = '0;
        end
        build_targets_shadow = 1'b1;
        res.ok = 1'b1;
      end
      default: begin
        retiring = role_active;
        role_active = role_shadow;
        role_shadow = role_spare;
        role_spare = retiring;
        build_targets_shadow = 1'b0;
        res.ok = 1'b1;
      end
    endcase
    res.active = role_active;
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic add_request(input func_t func, input logic [31:0] msr, input logic rsel,
                             input logic wsel, input logic setb, input logic quiet);
    msr_request_t req;
    req.func = func;
    req.msr = msr;
    req.read_sel = rsel;
    req.write_sel = wsel;
    req.set_bits = setb;
    req.quiet = quiet;
    pending_requests_q.push_back(req);
  endtask

  function automatic logic rand_bit();
    return 1'($urandom_range(0, 1));
  endfunction

  function automatic logic [31:0] range_base(input int unsigned sel);
    case (sel)
      0: return 32'h0000_0000;
      1: return 32'hC000_0000;
      default: return 32'hC001_0000;
    endcase
  endfunction

  function automatic logic [31:0] pick_msr();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      return msr_pool[POOL_IDX_W'($urandom_range(0, POOL_SIZE - 1))]
             | 32'($urandom_range(0, 3));
    end else if (pick < 80) begin
      return range_base($urandom_range(0, 2)) | 32'($urandom_range(0, 8191));
    end else if (pick < 90) begin
      return boundary_msrs[BND_IDX_W'($urandom_range(0, BOUNDARY_CNT - 1))];
    end
    return $urandom();
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_results_q.push_back(predict_intercept_result(cur_request));
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          in_valid <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (pending_requests_q.size() > 0) begin
          cur_request = pending_requests_q.pop_front();
          in_func <= cur_request.func;
          in_msr <= cur_request.msr;
          in_read_sel <= cur_request.read_sel;
          in_write_sel <= cur_request.write_sel;
          in_set_bits <= cur_request.set_bits;
          in_valid <= 1'b1;
          gap_left <= cur_request.quiet ? 0 : int'($urandom_range(0, 3));
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : result_monitor
    intercept_result_t exp_res;
    int                draw;
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (out_valid && !out_stall) begin
      if (expected_results_q.size() == 0) begin
        report_mismatch("result arrived with no request outstanding");
      end else begin
        exp_res = expected_results_q.pop_front();
        if (out_ok !== exp_res.ok)
          report_mismatch($sformatf("ok expected %0b got %0b", exp_res.ok, out_ok));
        if (out_read_intercept !== exp_res.read_icpt)
          report_mismatch($sformatf("read_intercept expected %0b got %0b",
                                    exp_res.read_icpt, out_read_intercept));
        if (out_write_intercept !== exp_res.write_icpt)
          report_mismatch($sformatf("write_intercept expected %0b got %0b",
                                    exp_res.write_icpt, out_write_intercept));
        if (out_active_buffer !== exp_res.active)
          report_mismatch($sformatf("active_buffer expected %0d got %0d",
                                    exp_res.active, out_active_buffer));
      end
      results_seen <= results_seen + 1;
      draw = ((results_seen / 100) % 4 == 0) ? 0 : int'($urandom_range(0, 3));
      stall_left <= draw;
      out_stall <= (draw != 0);
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= (stall_left > 1);
    end
  end

  initial begin
    int   n_directed;
    int   builds_left;
    int   pick;
    logic quiet;
    perm_map = '{default: '0};
    boundary_msrs = '{32'h0000_0000, 32'h0000_1FFF, 32'h0000_2000, 32'hBFFF_FFFF,
                      32'hC000_0000, 32'hC000_1FFF, 32'hC000_2000, 32'hC000_FFFF,
                      32'hC001_0000, 32'hC001_1FFF, 32'hC001_2000, 32'hFFFF_FFFF};
    for (int i = 0; i < POOL_SIZE; i++) begin
      msr_pool[POOL_IDX_W'(i)] = range_base($urandom_range(0, 2))
                                 | (32'($urandom_range(0, 8191)) & ~32'h3);
    end

    // Directed part: range edges, unmapped numbers, empty modify, begin builds and role rotation.
    add_request(FUNC_GET, 32'h0000_0000, 1'b0, 1'b0, 1'b0, 1'b0);
    add_request(FUNC_MODIFY, 32'h0000_0000, 1'b1, 1'b1, 1'b1, 1'b0);
    add_request(FUNC_GET, 32'h0000_0000, 1'b0, 1'b0, 1'b0, 1'b0);
    add_request(FUNC_MODIFY, 32'h0000_1FFF, 1'b0, 1'b1, 1'b1, 1'b0);
    add_request(FUNC_GET, 32'h0000_1FFF, 1'b1, 1'b1, 1'b1, 1'b0);
    add_request(FUNC_MODIFY, 32'hC000_0000, 1'b1, 1'b1, 1'b1, 1'b0);
    add_request(FUNC_GET, 32'hC000_0000, 1'b0, 1'b0, 1'b0, 1'b0);
    add_request(FUNC_MODIFY, 32'hC000_1FFF, 1'b1, 1'b0, 1'b1, 1'b0);
    add_request(FUNC_GET, 32'hC000_1FFF, 1'b0, 1'b0, 1'b0, 1'b0);
    add_request(FUNC_MODIFY, 32'hC001_0000, 1'b1, 1'b1, 1'b1, 1'b0);
    add_request(FUNC_MODIFY, 32'hC001_1FFF, 1'b1, 1'b1, 1'b1, 1'b0);
    add_request(FUNC_GET, 32'hC001_1FFF, 1'b0, 1'b0, 1'b0, 1'b0);
    add_request(FUNC_GET, 32'h0000_2000, 1'b0, 1'b0, 1'b0, 1'b0);
    add_request(FUNC_MODIFY, 32'hBFFF_FFFF, 1'b1, 1'b1, 1'b1, 1'b0);
    add_request(FUNC_GET, 32'hC000_2000, 1'b0, 1'b0, 1'b0, 1'b0);
    add_request(FUNC_MODIFY, 32'hC000_FFFF, 1'b1, 1'b1, 1'b1, 1'b0);
    add_request(FUNC_GET, 32'hC001_2000, 1'b0, 1'b0, 1'b0, 1'b0);
    add_request(FUNC_GET, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0, 1'b0);
    add_request(FUNC_MODIFY, 32'h0000_0000, 1'b0, 1'b0, 1'b0, 1'b0);
    add_request(FUNC_MODIFY, 32'h0000_0000, 1'b1, 1'b0, 1'b0, 1'b0);
    add_request(FUNC_GET, 32'h0000_0000, 1'b0, 1'b0, 1'b0, 1'b0);
    add_request(FUNC_COMMIT, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, 1'b0);
    add_request(FUNC_GET, 32'h0000_0000, 1'b0, 1'b0, 1'b0, 1'b0);
    add_request(FUNC_BEGIN, 32'h0000_0000, 1'b1, 1'b0, 1'b1, 1'b0);
    add_request(FUNC_BEGIN, 32'hC000_0001, 1'b0, 1'b1, 1'b0, 1'b0);
    add_request(FUNC_MODIFY, 32'hC000_0001, 1'b1, 1'b1, 1'b1, 1'b0);
    add_request(FUNC_GET, 32'hC000_0001, 1'b0, 1'b0, 1'b0, 1'b0);
    add_request(FUNC_COMMIT, 32'h0000_0000, 1'b0, 1'b0, 1'b0, 1'b0);
    add_request(FUNC_GET, 32'hC000_0001, 1'b0, 1'b0, 1'b0, 1'b0);
    n_directed = pending_requests_q.size();

    // Random part: build sequences with random content, mixed with loose traffic.
    builds_left = MAX_BUILDS;
    while (pending_requests_q.size() < n_directed + RANDOM_ITEMS) begin
      quiet = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 7) == 0 && builds_left > 0) begin
        builds_left--;
        add_request(FUNC_BEGIN, $urandom(), rand_bit(), rand_bit(), rand_bit(), quiet);
        if ($urandom_range(0, 5) == 0)
          add_request(FUNC_BEGIN, $urandom(), rand_bit(), rand_bit(), rand_bit(), quiet);
        repeat ($urandom_range(4, 12))
          add_request(FUNC_MODIFY, pick_msr(), rand_bit(), rand_bit(), rand_bit(), quiet);
        repeat ($urandom_range(0, 4))
          add_request(FUNC_GET, pick_msr(), rand_bit(), rand_bit(), rand_bit(), quiet);
        if ($urandom_range(0, 6) != 0)
          add_request(FUNC_COMMIT, $urandom(), rand_bit(), rand_bit(), rand_bit(), quiet);
      end else begin
        repeat ($urandom_range(5, 15)) begin
          pick = $urandom_range(0, 99);
          add_request(pick < 50 ? FUNC_GET : (pick < 93 ? FUNC_MODIFY : FUNC_COMMIT),
                      pick_msr(), rand_bit(), rand_bit(), rand_bit(), quiet);
        end
      end
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    do @(posedge clk);
    while (pending_requests_q.size() != 0 || in_valid || expected_results_q.size() != 0);
    repeat (16) @(posedge clk);
    if (expected_results_q.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_results_q.size()));
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #40000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

### sim.f
design/msrpm_pkg.sv
design/msr_permission_map_rotating_unit.sv
test/msr_permission_map_rotating_unit_tb.sv
